// ===== hw/rtl/mbps_pkg.sv =====
// Shared types and constants for the masked byte pattern scanner.
// Used by mbps_core and masked_byte_pattern_scanner; depends on nothing.
package mbps_pkg;

    localparam int DATA_W          = 8;
    localparam int PAT_BYTES       = 16;
    localparam int PAT_W           = PAT_BYTES * DATA_W;
    localparam int CARE_W          = PAT_BYTES;
    localparam int LEN_W           = 5;
    localparam int COUNT_W         = 32;
    localparam int OFFSET_W        = 31;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int MAX_PATTERN_DEF = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_CARE     = 2'd2,
        CFG_LEN      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PAT_W-1:0]  pattern;
        logic [CARE_W-1:0] care;
        logic [LEN_W-1:0]  length;
    } t_cfg;

    typedef struct packed {
        logic                found;
        logic                last;
        logic [OFFSET_W-1:0] offset;
    } t_result;

endpackage

// ===== hw/rtl/mbps_core.sv =====
// Byte window, saturating position count and masked window compare.
// Depends on mbps_pkg; instantiated by masked_byte_pattern_scanner.
module mbps_core
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_adv,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    output t_result           o_result
);

    localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [DATA_W-1:0]    r_window [MAX_PATTERN];
    logic [DATA_W-1:0]    n_window [MAX_PATTERN];
    logic [COUNT_W-1:0]   r_seen;
    logic [COUNT_W-1:0]   n_seen;
    logic [LEN_W-1:0]     len;
    logic [LEN_W-1:0]     pos [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] miss;
    logic [COUNT_W-1:0]   start;
    logic                 fits;

    always_comb begin
        if (i_cfg.length == '0) begin
            len = LEN_W'(1);
        end else if (i_cfg.length > LEN_W'(MAX_PATTERN)) begin
            len = LEN_W'(MAX_PATTERN);
        end else begin
            len = i_cfg.length;
        end
    end

    always_comb begin
        n_window[0] = i_data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    assign n_seen = (r_seen == '1) ? r_seen : r_seen + COUNT_W'(1);

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            pos[i]  = len - LEN_W'(1) - LEN_W'(i);
            miss[i] = (LEN_W'(i) < len) && i_cfg.care[i] &&
                      (n_window[pos[i][WIN_IDX_W-1:0]] != i_cfg.pattern[DATA_W*i +: DATA_W]);
        end
    end

    assign fits  = (n_seen >= COUNT_W'(len));
    assign start = n_seen - COUNT_W'(len);

    always_comb begin
        o_result.found  = fits && !(|miss);
        o_result.last   = i_last_byte;
        o_result.offset = '0;
        if (o_result.found) begin
            o_result.offset = start[COUNT_W-1] ? '1 : start[OFFSET_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_window[k] <= '0;
            end
        end else if (i_adv) begin
            if (i_last_byte) begin
                r_seen <= '0;
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    r_window[k] <= '0;
                end
            end else begin
                r_seen <= n_seen;
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    r_window[k] <= n_window[k];
                end
            end
        end
    end

`ifndef SYNTH
    a_end_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_last_byte |=> r_seen == '0)
        else $error("count not cleared after buffer end");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !i_last_byte |=> r_seen >= $past(r_seen))
        else $error("count went backward inside a buffer");

    a_match_needs_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.found |-> n_seen >= COUNT_W'(len))
        else $error("match reported before pattern fits");
`endif

endmodule

// ===== hw/rtl/masked_byte_pattern_scanner.sv =====
// Masked byte pattern scanner top level: input stage, configuration, result stage.
// Depends on mbps_pkg and mbps_core.
// Takes one byte per cycle sustained while the output is not stalled; an accepted
// byte is held in the input register, and its result is loaded into the output
// register when the output stage advances. The rate is set by the combinational
// masked compare of the newest byte window against up to MAX_PATTERN pattern
// bytes. A result is sent for every match (start offset, overlaps included) and for
// every last byte (buffer_end set); bytes with neither send nothing. The user must
// write registers only while the block is idle; the block does not enforce it.
module masked_byte_pattern_scanner
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DATA_W-1:0]     i_data_byte,
    input  logic                  i_last_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OFFSET_W-1:0]   o_match_offset,
    output logic                  o_match_found,
    output logic                  o_buffer_end
);

    t_cfg              r_cfg;
    logic              r_in_vld;
    logic [DATA_W-1:0] r_in_data;
    logic              r_in_last;
    logic              r_out_vld;
    t_result           r_out;
    t_result           core_result;
    logic              adv;
    logic              take;

    assign adv     = !(r_out_vld && i_stall);
    assign take    = r_in_vld && adv;
    assign o_stall = r_in_vld && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern <= '0;
            r_cfg.care    <= '0;
            r_cfg.length  <= LEN_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PAT_LOW:  r_cfg.pattern[CFG_DATA_W-1:0]     <= i_cfg_data;
                CFG_PAT_HIGH: r_cfg.pattern[PAT_W-1:CFG_DATA_W] <= i_cfg_data;
                CFG_CARE:     r_cfg.care   <= i_cfg_data[CARE_W-1:0];
                CFG_LEN:      r_cfg.length <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    mbps_core #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_adv       (take),
        .i_data_byte (r_in_data),
        .i_last_byte (r_in_last),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld && (core_result.found || core_result.last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= core_result;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_match_offset = r_out.offset;
    assign o_match_found  = r_out.found;
    assign o_buffer_end   = r_out.last;

`ifndef SYNTH
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_match_found || o_buffer_end))
        else $error("item sent with neither match nor buffer end");

    a_offset_zero_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_match_found |-> o_match_offset == '0)
        else $error("offset nonzero without a match");

    a_input_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && i_stall |=> r_in_vld && $stable(r_in_data))
        else $error("input stage item lost under output stall");
`endif

endmodule
